### hw/rtl/ook_pwm_frame_decoder_40bit_top_defines.svh
// Assertion helpers shared by the decoder RTL.
// Both expect i_clk and i_rst_n in the enclosing scope.
`ifndef OOK_PWM_FRAME_DECODER_40BIT_TOP_DEFINES_SVH
`define OOK_PWM_FRAME_DECODER_40BIT_TOP_DEFINES_SVH

// same-cycle implication
`define OPFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OPFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/opfd_pkg.sv
package opfd_pkg;

    // duration arithmetic width; scaled thresholds are truncated to it
    localparam int DUR_W = 16;
    localparam int IN_W  = 16;
    localparam int CMP_W = (DUR_W > IN_W) ? DUR_W : IN_W;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int PCT_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_TIME   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_PCT    = 8'd3;

    localparam logic [15:0]      RST_SHORT_TIME = 16'd562;
    localparam logic [15:0]      RST_LONG_TIME  = 16'd1688;
    localparam logic [15:0]      RST_TOL_TIME   = 16'd0;
    localparam logic [PCT_W-1:0] RST_TOL_PCT    = 7'd30;

    // x / 100 == (x >> 2) / 25; 1/25 ~= RECIP_25 / 2^RECIP_SH
    localparam int          RECIP_SH = 20;
    localparam logic [15:0] RECIP_25 = 16'd41943;
    localparam int          DIV_RES  = 25;

    // cycles from a config write until thresholds are valid
    localparam int DRV_LAT = 4;
    localparam int DRV_W   = $clog2(DRV_LAT + 1);

    localparam int FRAME_BITS = 40;
    localparam int CNT_W      = 6;
    localparam logic [15:0] FRAME_HDR = 16'hD5AA;
    localparam logic [7:0]  FRAME_FTR = 8'hAD;

    localparam int QDEPTH = 4;  // power of two
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [DUR_W-1:0] t_dur;

    typedef struct packed {
        t_dur ts;
        t_dur tl;
        t_dur s16;
        t_dur s8;
        t_dur delta;
        t_dur d2;
        t_dur d5;
        t_dur d7;
    } t_thr;

    typedef enum logic [1:0] {
        BC_BAD  = 2'd0,
        BC_ZERO = 2'd1,
        BC_ONE  = 2'd2
    } t_bit_cls;

    typedef struct packed {
        logic     pre_ok;
        t_bit_cls bcls;
        logic     last;
    } t_cls_item;

    function automatic logic abs_lt(input logic [CMP_W-1:0] a,
                                    input logic [CMP_W-1:0] b,
                                    input logic [CMP_W-1:0] lim);
        logic [CMP_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d < lim;
    endfunction

    function automatic logic [3:0] house_lut(input logic [3:0] code);
        logic [3:0] r;
        unique case (code)
            4'd0:  r = 4'd12;
            4'd1:  r = 4'd13;
            4'd2:  r = 4'd14;
            4'd3:  r = 4'd15;
            4'd4:  r = 4'd2;
            4'd5:  r = 4'd3;
            4'd6:  r = 4'd0;
            4'd7:  r = 4'd1;
            4'd8:  r = 4'd4;
            4'd9:  r = 4'd5;
            4'd10: r = 4'd6;
            4'd11: r = 4'd7;
            4'd12: r = 4'd10;
            4'd13: r = 4'd11;
            4'd14: r = 4'd8;
            default: r = 4'd9;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] unit_lut(input logic [2:0] code);
        logic [2:0] r;
        unique case (code)
            3'd0: r = 3'd0;
            3'd1: r = 3'd2;
            3'd2: r = 3'd1;
            3'd3: r = 3'd3;
            3'd4: r = 3'd4;
            3'd5: r = 3'd6;
            3'd6: r = 3'd5;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/opfd_queue.sv
`include "ook_pwm_frame_decoder_40bit_top_defines.svh"

module opfd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  opfd_pkg::t_cls_item i_data,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_pop,
    output opfd_pkg::t_cls_item o_data
);
    import opfd_pkg::*;

    t_cls_item          r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];

    `OPFD_ASSERT_NOW(a_no_push_full, r_cnt == QCNT_W'(QDEPTH), !i_push, "push into full queue")
    `OPFD_ASSERT_NOW(a_no_pop_empty, r_cnt == '0, !i_pop, "pop from empty queue")

endmodule

### hw/rtl/opfd_cfg.sv
module opfd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [opfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [opfd_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output opfd_pkg::t_thr                   o_thr,
    output logic                             o_busy
);
    import opfd_pkg::*;

    logic [15:0]       r_short, r_long, r_tol;
    logic [PCT_W-1:0]  r_pct;
    logic [DRV_W-1:0]  r_drv_cnt;

    // derive pipeline: product, reciprocal estimate, correction, thresholds
    // quotient needs 17 bits when the percent register holds more than 100
    logic [22:0]       r_prod;
    logic [16:0]       r_q0;
    logic [16:0]       r_dpct;
    t_thr              r_thr;

    logic [20:0]       w_y;
    logic [36:0]       w_m;
    logic [21:0]       w_rem;
    t_dur              w_delta;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short   <= RST_SHORT_TIME;
            r_long    <= RST_LONG_TIME;
            r_tol     <= RST_TOL_TIME;
            r_pct     <= RST_TOL_PCT;
            r_drv_cnt <= DRV_W'(DRV_LAT);
        end else begin
            if (i_cfg_valid) begin
                r_drv_cnt <= DRV_W'(DRV_LAT);
                unique case (i_cfg_index)
                    CFG_SHORT_TIME: r_short <= i_cfg_data;
                    CFG_LONG_TIME:  r_long  <= i_cfg_data;
                    CFG_TOL_TIME:   r_tol   <= i_cfg_data;
                    CFG_TOL_PCT:    r_pct   <= i_cfg_data[PCT_W-1:0];
                    default: ;
                endcase
            end else if (r_drv_cnt != '0) begin
                r_drv_cnt <= r_drv_cnt - 1'b1;
            end
        end
    end

    assign w_y     = r_prod[22:2];
    assign w_m     = 37'(w_y) * 37'(RECIP_25);
    // estimate is exact or one low
    assign w_rem   = 22'(w_y) - 22'(r_q0) * 22'(DIV_RES);
    assign w_delta = (r_tol != '0) ? DUR_W'(r_tol) : DUR_W'(r_dpct);

    always_ff @(posedge i_clk) begin
        r_prod       <= 23'(r_short) * 23'(r_pct);
        r_q0         <= w_m[RECIP_SH+16:RECIP_SH];
        r_dpct       <= 17'(r_q0) + 17'(w_rem >= 22'(DIV_RES));
        r_thr.ts     <= DUR_W'(r_short);
        r_thr.tl     <= DUR_W'(r_long);
        r_thr.s16    <= DUR_W'({r_short, 4'b0000});
        r_thr.s8     <= DUR_W'({r_short, 3'b000});
        r_thr.delta  <= w_delta;
        r_thr.d2     <= DUR_W'({w_delta, 1'b0});
        r_thr.d5     <= DUR_W'((DUR_W+3)'(w_delta) * (DUR_W+3)'(5));
        r_thr.d7     <= DUR_W'((DUR_W+3)'(w_delta) * (DUR_W+3)'(7));
    end

    assign o_thr  = r_thr;
    assign o_busy = (r_drv_cnt != '0);

endmodule

### hw/rtl/opfd_front.sv
module opfd_front (
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [opfd_pkg::IN_W-1:0]   i_high_us,
    input  logic [opfd_pkg::IN_W-1:0]   i_low_us,
    input  logic                        i_capture_end,
    input  opfd_pkg::t_thr              i_thr,
    input  logic                        i_busy,
    input  logic                        i_q_full,
    output logic                        o_push,
    output opfd_pkg::t_cls_item         o_item
);
    import opfd_pkg::*;

    logic [CMP_W-1:0] w_hi, w_lo;
    logic             w_hi_ok, w_lo0, w_lo1;

    assign w_hi = CMP_W'(i_high_us);
    assign w_lo = CMP_W'(i_low_us);

    assign w_hi_ok = abs_lt(w_hi, CMP_W'(i_thr.ts), CMP_W'(i_thr.delta));
    assign w_lo0   = abs_lt(w_lo, CMP_W'(i_thr.ts), CMP_W'(i_thr.delta));
    assign w_lo1   = abs_lt(w_lo, CMP_W'(i_thr.tl), CMP_W'(i_thr.d2));

    always_comb begin
        o_item.pre_ok = abs_lt(w_hi, CMP_W'(i_thr.s16), CMP_W'(i_thr.d7))
                     && abs_lt(w_lo, CMP_W'(i_thr.s8), CMP_W'(i_thr.d5));
        o_item.last   = i_capture_end;
        priority if (!w_hi_ok) begin
            o_item.bcls = BC_BAD;
        end else if (w_lo0) begin
            o_item.bcls = BC_ZERO;
        end else if (w_lo1) begin
            o_item.bcls = BC_ONE;
        end else begin
            o_item.bcls = BC_BAD;
        end
    end

    assign o_in_stall = i_busy || i_q_full;
    assign o_push     = i_in_valid && !o_in_stall;

endmodule

### hw/rtl/opfd_back.sv
`include "ook_pwm_frame_decoder_40bit_top_defines.svh"

module opfd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  opfd_pkg::t_cls_item   i_item,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_status,
    output logic [39:0]           o_raw_frame,
    output logic [3:0]            o_house_letter,
    output logic [4:0]            o_unit_number,
    output logic [1:0]            o_command_class
);
    import opfd_pkg::*;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_BITS   = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [FRAME_BITS-1:0] r_shift, n_shift, w_sh;
    logic [CNT_W-1:0]      r_cnt, n_cnt, w_cnt1;
    logic                  w_res, w_fail;

    logic                  r_out_valid;
    logic                  r_status;
    logic [39:0]           r_raw;
    logic [3:0]            r_house;
    logic [4:0]            r_unit;
    logic [1:0]            r_cls;

    logic [7:0]            w_hb, w_cmd;
    logic                  w_frame_ok;

    assign o_pop  = i_q_valid && (!r_out_valid || !i_out_stall);
    assign w_sh   = {r_shift[FRAME_BITS-2:0], (i_item.bcls == BC_ONE)};
    assign w_cnt1 = r_cnt + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        w_res   = 1'b0;
        w_fail  = 1'b0;
        unique case (r_phase)
            PH_SEARCH: begin
                if (i_item.pre_ok) begin
                    n_phase = PH_BITS;
                    n_shift = '0;
                    n_cnt   = '0;
                end
            end
            PH_BITS: begin
                if (i_item.bcls == BC_BAD) begin
                    w_res   = 1'b1;
                    w_fail  = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_shift = w_sh;
                    n_cnt   = w_cnt1;
                    if (w_cnt1 >= CNT_W'(FRAME_BITS)) begin
                        w_res   = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_DONE: ;
            default: n_phase = PH_SEARCH;
        endcase
        // end of capture: fail unless a verdict was already given
        if (i_item.last) begin
            if (n_phase != PH_DONE) begin
                w_res  = 1'b1;
                w_fail = 1'b1;
            end
            n_phase = PH_SEARCH;
            n_shift = '0;
            n_cnt   = '0;
        end
    end

    assign w_hb       = w_sh[23:16];
    assign w_cmd      = w_sh[15:8];
    assign w_frame_ok = (w_sh[39:24] == FRAME_HDR) && (w_sh[7:0] == FRAME_FTR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_shift     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_shift     <= n_shift;
                r_cnt       <= n_cnt;
                r_out_valid <= w_res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_res) begin
            if (w_fail || !w_frame_ok) begin
                r_status <= 1'b1;
                r_raw    <= '0;
                r_house  <= '0;
                r_unit   <= '0;
                r_cls    <= '0;
            end else begin
                r_status <= 1'b0;
                r_raw    <= w_sh;
                r_house  <= house_lut(w_hb[7:4]);
                r_unit   <= {1'b0, w_hb[2], unit_lut({w_cmd[6], w_cmd[4:3]})} + 5'd1;
                if (w_cmd[7]) begin
                    r_cls <= w_cmd[4] ? 2'd2 : 2'd3;
                end else begin
                    r_cls <= w_cmd[5] ? 2'd1 : 2'd0;
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_raw_frame     = r_raw;
    assign o_house_letter  = r_house;
    assign o_unit_number   = r_unit;
    assign o_command_class = r_cls;

    `OPFD_ASSERT_NOW(a_cnt_range, r_phase == PH_BITS, r_cnt < CNT_W'(FRAME_BITS), "bit count past frame length")
    `OPFD_ASSERT_NOW(a_search_clear, r_phase == PH_SEARCH, r_cnt == '0 && r_shift == '0, "search phase with stale frame")
    `OPFD_ASSERT_NOW(a_ok_has_hdr, r_out_valid && !r_status, r_raw[39:24] == FRAME_HDR && r_unit != '0, "decoded result without header")
    `OPFD_ASSERT_NOW(a_fail_zero, r_out_valid && r_status, r_raw == '0 && r_unit == '0, "reject result not cleared")

endmodule

### hw/rtl/ook_pwm_frame_decoder_40bit_top.sv
// Channel   Direction  Handshake              Request contents
// in        sink       i_in_valid/o_in_stall  i_high_us, i_low_us, i_capture_end
// out       source     o_out_valid/i_out_stall o_status, o_raw_frame, o_house_letter,
//                                             o_unit_number, o_command_class
// cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One pulse-pair request per cycle while the input is not stalled; a taken pair passes
// through the queue, and the sequencer then loads its result into the output register.
// Rate is set by the pair classifier (parallel abs-diff compares) and the frame
// sequencer, each one request per cycle; the four-entry queue between them absorbs
// output stalls.
// After reset and after every config write the input stalls while the
// tolerance thresholds are rebuilt (percent product, divide by 100, scaled limits).
// A stalled result holds in the output register; reset is synchronous, active low.
module ook_pwm_frame_decoder_40bit_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [opfd_pkg::IN_W-1:0]       i_high_us,
    input  logic [opfd_pkg::IN_W-1:0]       i_low_us,
    input  logic                            i_capture_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_status,
    output logic [39:0]                     o_raw_frame,
    output logic [3:0]                      o_house_letter,
    output logic [4:0]                      o_unit_number,
    output logic [1:0]                      o_command_class,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [opfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [opfd_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import opfd_pkg::*;

    t_thr       w_thr;
    logic       w_busy;
    logic       w_push, w_q_full, w_q_valid, w_pop;
    t_cls_item  w_front_item, w_back_item;

    // config registers and derived thresholds
    opfd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_thr       (w_thr),
        .o_busy      (w_busy)
    );

    // classify each pair against the windows: preamble hit, bit 0/1 or bad
    opfd_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_high_us     (i_high_us),
        .i_low_us      (i_low_us),
        .i_capture_end (i_capture_end),
        .i_thr         (w_thr),
        .i_busy        (w_busy),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    // classified pairs waiting for the sequencer
    opfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_back_item)
    );

    // phase tracking, bit shifting, verdict and field decode
    opfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_item          (w_back_item),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_raw_frame     (o_raw_frame),
        .o_house_letter  (o_house_letter),
        .o_unit_number   (o_unit_number),
        .o_command_class (o_command_class)
    );

endmodule

### verif/ook_pwm_frame_decoder_40bit_top_tb.sv
`timescale 1ns / 1ps

module ook_pwm_frame_decoder_40bit_top_tb;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 4;
    // pipeline plus the four-deep queue: enough for pairs that leave no result
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;

    // lookup tables, one nibble per entry, entry 0 in the low nibble
    localparam logic [63:0] HOUSE_MAP = 64'h98BA_7654_1032_FEDC;
    localparam logic [31:0] UNIT_MAP  = 32'h7564_3120;

    typedef enum logic [2:0] {
        SEEK_PREAMBLE = 3'b001,
        READ_BITS     = 3'b010,
        VERDICT_GIVEN = 3'b100
    } t_rx_phase;

    typedef enum logic {
        ST_DECODED  = 1'b0,
        ST_REJECTED = 1'b1
    } t_frame_status;

    typedef enum logic [1:0] {
        CMD_ON     = 2'd0,
        CMD_OFF    = 2'd1,
        CMD_DIM    = 2'd2,
        CMD_BRIGHT = 2'd3
    } t_cmd_class;

    typedef struct packed {
        logic        status;
        logic [39:0] raw;
        logic [3:0]  house;
        logic [4:0]  unit_num;
        logic [1:0]  cls;
    } t_decode_result;

    // Frame decode predictor plus the queue of verdicts still owed by the block.
    class frame_scoreboard;
        logic [15:0]                        short_t;
        logic [15:0]                        long_t;
        logic [15:0]                        tol_t;
        logic [opfd_pkg::PCT_W-1:0]         tol_pct;
        logic [15:0]                        delta;
        logic [15:0]                        delta2;
        logic [15:0]                        delta5;
        logic [15:0]                        delta7;
        logic [15:0]                        pre_high;
        logic [15:0]                        pre_low;
        t_rx_phase                          phase;
        logic [39:0]                        shift_reg;
        int unsigned                        bit_cnt;
        t_decode_result                     verdicts[$];
        int unsigned                        predicted;
        int unsigned                        errors;

        function new();
            short_t   = opfd_pkg::RST_SHORT_TIME;
            long_t    = opfd_pkg::RST_LONG_TIME;
            tol_t     = opfd_pkg::RST_TOL_TIME;
            tol_pct   = opfd_pkg::RST_TOL_PCT;
            phase     = SEEK_PREAMBLE;
            shift_reg = '0;
            bit_cnt   = 0;
            predicted = 0;
            errors    = 0;
            update_limits();
        endfunction

        // every limit is cut to the 16-bit duration width
        function void update_limits();
            logic [31:0] prod;
            prod     = 32'(short_t) * 32'(tol_pct);
            delta    = (tol_t != 16'd0) ? tol_t : 16'(prod / 100);
            delta2   = 16'(delta * 2);
            delta5   = 16'(delta * 5);
            delta7   = 16'(delta * 7);
            pre_high = 16'(short_t * 16);
            pre_low  = 16'(short_t * 8);
        endfunction

        function void set_reg(logic [opfd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                opfd_pkg::CFG_SHORT_TIME: short_t = data;
                opfd_pkg::CFG_LONG_TIME:  long_t  = data;
                opfd_pkg::CFG_TOL_TIME:   tol_t   = data;
                opfd_pkg::CFG_TOL_PCT:    tol_pct = data[opfd_pkg::PCT_W-1:0];
                default: ;
            endcase
            update_limits();
        endfunction

        function logic [15:0] span(logic [15:0] a, logic [15:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void push_verdict(t_decode_result r);
            verdicts.push_back(r);
            predicted++;
        endfunction

        function void push_reject();
            t_decode_result r;
            r        = '0;
            r.status = ST_REJECTED;
            push_verdict(r);
        endfunction

        function void note_pair(logic [15:0] hi, logic [15:0] lo, logic last);
            t_decode_result r;
            logic [7:0]     addr_oct;
            logic [7:0]     ctl_oct;
            logic [2:0]     ubits;
            logic           bit_val;
            logic           ok;
            case (phase)
                SEEK_PREAMBLE: begin
                    if (span(hi, pre_high) < delta7 && span(lo, pre_low) < delta5) begin
                        phase     = READ_BITS;
                        shift_reg = '0;
                        bit_cnt   = 0;
                    end
                end
                READ_BITS: begin
                    ok      = 1'b1;
                    bit_val = 1'b0;
                    if (span(hi, short_t) >= delta) ok = 1'b0;
                    else if (span(lo, short_t) < delta) bit_val = 1'b0;
                    else if (span(lo, long_t) < delta2) bit_val = 1'b1;
                    else ok = 1'b0;
                    if (!ok) begin
                        push_reject();
                        phase = VERDICT_GIVEN;
                    end else begin
                        shift_reg = {shift_reg[38:0], bit_val};
                        bit_cnt++;
                        if (bit_cnt >= opfd_pkg::FRAME_BITS) begin
                            phase = VERDICT_GIVEN;
                            if (shift_reg[39:24] != opfd_pkg::FRAME_HDR ||
                                shift_reg[7:0] != opfd_pkg::FRAME_FTR) begin
                                push_reject();
                            end else begin
                                addr_oct   = shift_reg[23:16];
                                ctl_oct    = shift_reg[15:8];
                                ubits      = {ctl_oct[6], ctl_oct[4:3]};
                                r          = '0;
                                r.status   = ST_DECODED;
                                r.raw      = shift_reg;
                                r.house    = HOUSE_MAP[{addr_oct[7:4], 2'b00} +: 4];
                                r.unit_num = {addr_oct[2], 3'b000}
                                           + 5'(UNIT_MAP[{ubits, 2'b00} +: 3]) + 5'd1;
                                if (ctl_oct[7]) r.cls = ctl_oct[4] ? CMD_DIM : CMD_BRIGHT;
                                else r.cls = ctl_oct[5] ? CMD_OFF : CMD_ON;
                                push_verdict(r);
                            end
                        end
                    end
                end
                default: ;
            endcase
            // end of capture: owe a reject if nothing was decided yet
            if (last) begin
                if (phase != VERDICT_GIVEN) push_reject();
                phase     = SEEK_PREAMBLE;
                shift_reg = '0;
                bit_cnt   = 0;
            end
        endfunction

        function void check_result(logic st, logic [39:0] raw, logic [3:0] house,
                                   logic [4:0] unit_num, logic [1:0] cls);
            t_decode_result want;
            if (verdicts.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: st=%0d raw=%010h house=%0d unit=%0d cls=%0d",
                             st, raw, house, unit_num, cls);
                return;
            end
            want = verdicts.pop_front();
            if (st !== want.status || raw !== want.raw || house !== want.house ||
                unit_num !== want.unit_num || cls !== want.cls) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: got st=%0d raw=%010h house=%0d unit=%0d cls=%0d, want st=%0d raw=%010h house=%0d unit=%0d cls=%0d",
                             st, raw, house, unit_num, cls, want.status, want.raw,
                             want.house, want.unit_num, want.cls);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT inputs, all at known values from time zero
    // ------------------------------------------------------------------
    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_in_valid    = 1'b0;
    logic                              o_in_stall;
    logic [opfd_pkg::IN_W-1:0]         i_high_us     = '0;
    logic [opfd_pkg::IN_W-1:0]         i_low_us      = '0;
    logic                              i_capture_end = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_stall   = 1'b0;
    logic                              o_status;
    logic [39:0]                       o_raw_frame;
    logic [3:0]                        o_house_letter;
    logic [4:0]                        o_unit_number;
    logic [1:0]                        o_command_class;
    logic                              i_cfg_valid   = 1'b0;
    logic                              o_cfg_ready;
    logic [opfd_pkg::CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [opfd_pkg::CFG_DAT_W-1:0]    i_cfg_data    = '0;

    frame_scoreboard sb = new();

    // idling switches, redrawn per capture so quiet stretches also occur
    bit          in_idle     = 1'b0;
    bit          out_idle    = 1'b0;
    int unsigned stall_left  = 0;
    int unsigned pairs_sent  = 0;
    int unsigned cycle_count = 0;

    ook_pwm_frame_decoder_40bit_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_high_us       (i_high_us),
        .i_low_us        (i_low_us),
        .i_capture_end   (i_capture_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_raw_frame     (o_raw_frame),
        .o_house_letter  (o_house_letter),
        .o_unit_number   (o_unit_number),
        .o_command_class (o_command_class),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** ook_pwm_frame_decoder_40bit_top: FAILED **");
            $finish;
        end
    end

    // Result side: a request is taken when valid is high and stall is low,
    // both sampled before the edge updates. After each one, if out_idle is set, stall
    // is held for a random number of cycles, possibly none.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_status, o_raw_frame, o_house_letter, o_unit_number,
                                o_command_class);
                stall_left = out_idle ? $urandom_range(0, 7) : 0;
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // value within lim-1 of center, clamped to the field range
    function automatic logic [15:0] near_us(logic [15:0] center, logic [15:0] lim);
        int v;
        if (lim < 16'd2) return center;
        v = int'(center) + int'($urandom_range(0, 2 * (lim - 1))) - int'(lim) + 1;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    // value at least lim away from center, where the range allows it
    function automatic logic [15:0] off_us(logic [15:0] center, logic [15:0] lim);
        int v;
        v = int'(center) + int'(lim) + int'($urandom_range(0, 400));
        if (v > 65535) v = int'(center) - int'(lim) - int'($urandom_range(0, 400));
        if (v < 0) v = 0;
        return 16'(v);
    endfunction

    // One pulse-pair request. Valid stays high into the next request when
    // there is no idle gap, so it is never lowered and raised in one step.
    task automatic send_pair(input logic [15:0] hi, input logic [15:0] lo, input logic last);
        int unsigned gap;
        gap = in_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_high_us     <= hi;
        i_low_us      <= lo;
        i_capture_end <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pair(hi, lo, last);
        pairs_sent++;
    endtask

    // Writes all four registers back to back; valid held high between them.
    task automatic write_config(input logic [15:0] st, input logic [15:0] lt,
                                input logic [15:0] tt, input logic [6:0] pct);
        logic [opfd_pkg::CFG_IDX_W-1:0] idx[4];
        logic [15:0]                    vals[4];
        int                             k;
        idx  = '{opfd_pkg::CFG_SHORT_TIME, opfd_pkg::CFG_LONG_TIME,
                 opfd_pkg::CFG_TOL_TIME, opfd_pkg::CFG_TOL_PCT};
        vals = '{st, lt, tt, 16'(pct)};
        for (k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(idx[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Timing that still lets clean frames decode: long >= 2x short and
    // tolerance <= short/4 keep the bit windows apart.
    task automatic random_config(input bit use_tol_time);
        logic [15:0] st;
        logic [15:0] lt;
        st = 16'($urandom_range(100, 3000));
        lt = 16'(st * $urandom_range(2, 4));
        if (use_tol_time)
            write_config(st, lt, 16'($urandom_range(1, st / 4)), 7'($urandom_range(0, 100)));
        else
            write_config(st, lt, 16'd0, 7'($urandom_range(5, 25)));
    endtask

    // Idle the input, let every owed verdict come out, then let trailing
    // pairs that leave no result drain through the pipeline.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One capture: optional noise, preamble, frame bits, then pairs past the
    // verdict. Half are clean frames; the rest have a broken header/footer, a bad
    // pulse, too few bits, or pure noise.
    task automatic run_capture();
        logic [15:0] his[$];
        logic [15:0] los[$];
        logic [39:0] word;
        int unsigned pick;
        int unsigned nbits;
        int unsigned bad_at;
        int unsigned i;
        pick     = $urandom_range(0, 99);
        in_idle  = $urandom_range(0, 3) != 0;
        out_idle = $urandom_range(0, 3) != 0;
        word     = {opfd_pkg::FRAME_HDR, 8'($urandom), 8'($urandom), opfd_pkg::FRAME_FTR};
        repeat ($urandom_range(0, 2)) begin
            his.push_back(16'($urandom));
            los.push_back(16'($urandom));
        end
        if (pick >= 85) begin
            repeat ($urandom_range(1, 3)) begin
                his.push_back(16'($urandom));
                los.push_back(16'($urandom));
            end
        end else begin
            his.push_back(near_us(sb.pre_high, sb.delta7));
            los.push_back(near_us(sb.pre_low, sb.delta5));
            nbits  = 40;
            bad_at = 40;
            if (pick >= 50 && pick < 62) begin
                // flip one header or footer bit
                i = $urandom_range(0, 1) ? $urandom_range(24, 39) : $urandom_range(0, 7);
                word[i] = ~word[i];
            end else if (pick >= 62 && pick < 75) begin
                bad_at = $urandom_range(0, 39);
            end else if (pick >= 75) begin
                nbits = $urandom_range(0, 39);
            end
            for (i = 0; i < nbits && i <= bad_at; i++) begin
                if (i == bad_at) begin
                    if ($urandom_range(0, 1)) begin
                        his.push_back(off_us(sb.short_t, sb.delta));
                        los.push_back(near_us(sb.short_t, sb.delta));
                    end else begin
                        his.push_back(near_us(sb.short_t, sb.delta));
                        los.push_back(off_us(sb.long_t, 16'(sb.delta2 + sb.delta)));
                    end
                end else begin
                    his.push_back(near_us(sb.short_t, sb.delta));
                    los.push_back(word[39 - i] ? near_us(sb.long_t, sb.delta2)
                                               : near_us(sb.short_t, sb.delta));
                end
            end
            repeat ($urandom_range(0, 3)) begin
                his.push_back(16'($urandom));
                los.push_back(16'($urandom));
            end
        end
        for (i = 0; i < his.size(); i++)
            send_pair(his[i], los[i], i == his.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int          ph;
        int unsigned budget;
        int unsigned start_cnt;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset timing: short 562, long 1688, tolerance 168.
        // Extremes of the fields, each with its own capture end.
        send_pair(16'd0, 16'd0, 1'b1);
        send_pair(16'hFFFF, 16'hFFFF, 1'b1);
        // bad low pulse right after the preamble, then ignored pairs to the end
        send_pair(sb.pre_high, sb.pre_low, 1'b0);
        send_pair(sb.short_t, 16'(sb.long_t + sb.delta2), 1'b0);
        send_pair(sb.short_t, sb.short_t, 1'b0);
        send_pair(16'd0, 16'd0, 1'b1);
        // preamble and bits on the inner edges of their windows, too few bits
        send_pair(16'(sb.pre_high + sb.delta7 - 1), 16'(sb.pre_low - sb.delta5 + 1), 1'b0);
        send_pair(16'(sb.short_t - sb.delta + 1), 16'(sb.short_t + sb.delta - 1), 1'b0);
        send_pair(sb.short_t, 16'(sb.long_t - sb.delta2 + 1), 1'b1);
        // preamble just outside its window: never found
        send_pair(16'(sb.pre_high + sb.delta7), sb.pre_low, 1'b0);
        send_pair(sb.pre_high, 16'(sb.pre_low + sb.delta5), 1'b1);
        // bad high pulse on the capture's last pair: one reject only
        send_pair(sb.pre_high, sb.pre_low, 1'b0);
        send_pair(16'(sb.short_t + sb.delta), sb.short_t, 1'b1);
        // preamble alone
        send_pair(sb.pre_high, sb.pre_low, 1'b1);

        // Random part over several timing setups, extremes included.
        for (ph = 0; ph < 8; ph++) begin
            if (ph != 0) begin
                drain();
                case (ph)
                    2: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd100);
                    3: write_config(16'd1, 16'd1, 16'd0, 7'd0);     // zero tolerance
                    4: write_config(16'd562, 16'd2248, 16'd0, 7'd100);
                    5: random_config(1'b1);
                    default: random_config(ph[0]);
                endcase
            end
            budget    = (ph == 2 || ph == 3) ? 50 : 180;
            start_cnt = pairs_sent;
            while (pairs_sent - start_cnt < budget) run_capture();
        end

        drain();
        if (sb.errors == 0 && sb.verdicts.size() == 0) begin
            $display("** ook_pwm_frame_decoder_40bit_top: PASSED **");
        end else begin
            $display("** ook_pwm_frame_decoder_40bit_top: FAILED **");
        end
        $finish;
    end

endmodule

### ook_pwm_frame_decoder_40bit_top.f
+incdir+hw/rtl
hw/rtl/opfd_pkg.sv
hw/rtl/opfd_queue.sv
hw/rtl/opfd_cfg.sv
hw/rtl/opfd_front.sv
hw/rtl/opfd_back.sv
hw/rtl/ook_pwm_frame_decoder_40bit_top.sv
verif/ook_pwm_frame_decoder_40bit_top_tb.sv
